// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dnsrp_pkg.sv =====
// Shared types and constants of the DNS response parser.
// No dependencies; imported by dnsrp_res_fifo, dnsrp_parse and dns_response_parser.
package dnsrp_pkg;

  localparam int MAX_KEPT_ANSWERS  = 4;
  localparam int MAX_MESSAGE_BYTES = 512;
  localparam int CNT_W             = $clog2(MAX_KEPT_ANSWERS + 1);

  // Output field widths
  localparam int IDX_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 3;
  localparam int TDATA_W  = 144;

  // Message constants
  localparam logic [7:0]  PTR_MARK    = 8'hC0;
  localparam logic [7:0]  QFIXED_LEN  = 8'd4;
  localparam logic [7:0]  AHDR_LEN    = 8'd8;
  localparam logic [7:0]  AFIXED_LEN  = 8'd10;
  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] TYPE_AAAA   = 16'd28;
  localparam logic [15:0] CLASS_IN    = 16'd1;
  localparam logic [15:0] LEN_A       = 16'd4;
  localparam logic [15:0] LEN_AAAA    = 16'd16;
  localparam logic [15:0] POS_ID_END  = 16'd1;
  localparam logic [15:0] POS_AN_END  = 16'd7;
  localparam logic [15:0] POS_HDR_END = 16'd11;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

  // Result kinds
  localparam logic KIND_ANSWER  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_ID = 1'b0;
  localparam logic CFG_MAX_TTL     = 1'b1;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_READY_LIMIT = FIFO_DEPTH - 4;

  typedef struct packed {
    logic                item_kind;
    logic [IDX_W-1:0]    answer_index;
    logic                answer_ok;
    logic                addr_is_v6;
    logic [63:0]         addr_high;
    logic [63:0]         addr_low;
    logic [STATUS_W-1:0] overall_status;
    logic [COUNT_W-1:0]  answer_count;
    logic                last_result;
  } result_t;

  // Results produced by one message byte: an answer, a summary, or both in that order
  typedef struct packed {
    logic    ans_valid;
    logic    sum_valid;
    result_t ans;
    result_t sum;
  } push_t;

endpackage

// ===== rtl/dns_response_parser.sv =====
// DNS response parser, top level.
// Depends on dnsrp_pkg, dnsrp_parse, dnsrp_res_fifo and assert_macros.svh.
//
// Usage:
//   The s_axis channel carries one message byte per word; s_axis_tlast marks the
//   final byte of a message. The m_axis channel carries results: one answer word
//   per kept answer record (m_axis_tuser low) and one summary word per message
//   (m_axis_tuser high, m_axis_tlast high). When a byte closes both an answer and
//   the message, the answer word comes out before the summary.
//   The cfg port writes expected_id (index 0) and max_ttl (index 1); write only
//   while no message is in flight.
// Timing:
//   A byte is taken into the input register, parsed in the next cycle, and its
//   results enter the result queue at the edge that ends that cycle; m_axis
//   shows the queue head. One byte is taken every cycle while the queue holds
//   no more than four results; the parse loop over the per-message state,
//   which advances once per byte, sets that rate.
// Reset and stall:
//   rst clears the parse state, the queue and the registers to their defaults
//   (expected_id 0, max_ttl 0x7FFFFFFF). When m_axis stalls, results wait in the
//   eight-entry queue and s_axis_tready drops once it holds more than four.
`include "assert_macros.svh"

module dns_response_parser (
  input  logic                          clk,
  input  logic                          rst,
  // input byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // last_byte
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] answer_index, [2] answer_ok, [3] addr_is_v6, [67:4] addr_high,
  // [131:68] addr_low, [133:132] overall_status, [136:134] answer_count, rest zero
  output logic [dnsrp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,   // [0] item_kind
  output logic                          m_axis_tlast,   // last_result
  // configuration writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);
  import dnsrp_pkg::*;

  logic [15:0]           expected_id;
  logic [31:0]           max_ttl;
  logic                  stage_valid;
  logic [7:0]            stage_byte;
  logic                  stage_last;
  push_t                 push;
  result_t               head;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 16'd0;
      max_ttl     <= 32'h7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID: expected_id <= cfg_data[15:0];
        CFG_MAX_TTL:     max_ttl     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Take a byte only while the queue has room for the staged byte's results and this one's
  assign s_axis_tready = (fifo_count <= FIFO_CNT_W'(FIFO_READY_LIMIT));

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_byte <= s_axis_tdata;
      stage_last <= s_axis_tlast;
    end
  end

  dnsrp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (stage_valid),
    .item_byte   (stage_byte),
    .item_last   (stage_last),
    .expected_id (expected_id),
    .max_ttl     (max_ttl),
    .push        (push)
  );

  dnsrp_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_axis_tready),
    .head      (head),
    .not_empty (m_axis_tvalid),
    .count     (fifo_count)
  );

  // Pack the head result onto the output word
  assign m_axis_tdata = {7'd0, head.answer_count, head.overall_status, head.addr_low,
                         head.addr_high, head.addr_is_v6, head.answer_ok,
                         head.answer_index};
  assign m_axis_tuser = head.item_kind;
  assign m_axis_tlast = head.last_result;

  // A staged byte always finds room for both of its results
  `CHECK_ALWAYS(a_stage_room, !stage_valid || (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)), "result queue too full for staged byte")
  // The final byte of a message leaves a summary to deliver
  `CHECK_NEXT(a_summary_queued, stage_valid && stage_last, m_axis_tvalid, "no result after final byte")
  // Every summary word closes its message
  `CHECK_ALWAYS(a_summary_last, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast, "summary without last flag")

endmodule

// ===== rtl/dnsrp_res_fifo.sv =====
// Result queue of the DNS response parser: takes up to two results a cycle, gives one.
// Depends on dnsrp_pkg.
module dnsrp_res_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  dnsrp_pkg::push_t             push,
  input  logic                         pop,
  output dnsrp_pkg::result_t           head,
  output logic                         not_empty,
  output logic [dnsrp_pkg::FIFO_CNT_W-1:0] count
);
  import dnsrp_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W-1:0] wr_second;
  logic [FIFO_CNT_W-1:0] count_next;
  logic                  do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];
  // The summary lands behind the answer when both arrive together
  assign wr_second = wr_ptr + FIFO_PTR_W'(push.ans_valid);

  always_comb begin
    count_next = count + FIFO_CNT_W'(push.ans_valid) + FIFO_CNT_W'(push.sum_valid)
                 - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.ans_valid) begin
      mem[wr_ptr] <= push.ans;
    end
    if (push.sum_valid) begin
      mem[wr_second] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.ans_valid) + FIFO_PTR_W'(push.sum_valid);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(do_pop);
      count  <= count_next;
    end
  end

endmodule

// ===== rtl/dnsrp_parse.sv =====
// Byte-serial parse of a DNS response: header check, name skipping, answer decode.
// Depends on dnsrp_pkg.
module dnsrp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [7:0]       item_byte,
  input  logic             item_last,
  input  logic [15:0]      expected_id,
  input  logic [31:0]      max_ttl,
  output dnsrp_pkg::push_t push
);
  import dnsrp_pkg::*;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QNAME  = 4'd1;
  localparam logic [3:0] PH_QLABEL = 4'd2;
  localparam logic [3:0] PH_QPTR   = 4'd3;
  localparam logic [3:0] PH_QFIXED = 4'd4;
  localparam logic [3:0] PH_ANAME  = 4'd5;
  localparam logic [3:0] PH_ALABEL = 4'd6;
  localparam logic [3:0] PH_APTR   = 4'd7;
  localparam logic [3:0] PH_AFIXED = 4'd8;
  localparam logic [3:0] PH_RDATA  = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  logic [3:0]          phase, phase_next;
  logic [15:0]         pos, pos_next;
  logic [7:0]          label, label_next;
  logic [15:0]         fs, fs_next;
  logic [63:0]         hdr, hdr_next;
  logic [15:0]         rdata, rdata_next;
  logic [127:0]        addr, addr_next;
  logic [CNT_W-1:0]    wanted, wanted_next;
  logic [CNT_W-1:0]    number, number_next;
  logic [STATUS_W-1:0] err, err_next;
  logic                emit;
  logic                base_ok, is_a, is_aaaa;
  logic [STATUS_W-1:0] sum_status;

  always_comb begin
    phase_next  = phase;
    label_next  = label;
    fs_next     = fs;
    hdr_next    = hdr;
    rdata_next  = rdata;
    addr_next   = addr;
    wanted_next = wanted;
    number_next = number;
    err_next    = err;
    emit        = 1'b0;

    if (phase != PH_DONE && pos >= 16'(MAX_MESSAGE_BYTES)) begin
      err_next   = ST_MALFORMED;
      phase_next = PH_DONE;
    end else if (phase != PH_DONE) begin
      unique case (phase)
        PH_HEADER: begin
          fs_next = {fs[7:0], item_byte};
          if (pos == POS_ID_END) hdr_next[63:48] = fs_next;
          if (pos == POS_AN_END) hdr_next[15:0] = fs_next;
          if (pos == POS_HDR_END) begin
            if (hdr[63:48] != expected_id || hdr[15:0] == 16'd0) begin
              err_next   = ST_MISMATCH;
              phase_next = PH_DONE;
            end else begin
              wanted_next = (hdr[15:0] < 16'(MAX_KEPT_ANSWERS)) ? CNT_W'(hdr[15:0])
                                                                 : CNT_W'(MAX_KEPT_ANSWERS);
              phase_next  = PH_QNAME;
            end
          end
        end
        PH_QNAME: begin
          if (item_byte == 8'd0) begin
            phase_next = PH_QFIXED;
            label_next = '0;
          end else if ((item_byte & PTR_MARK) == PTR_MARK) begin
            phase_next = PH_QPTR;
          end else begin
            label_next = item_byte;
            phase_next = PH_QLABEL;
          end
        end
        PH_QLABEL: begin
          label_next = label - 8'd1;
          if (label == 8'd1) phase_next = PH_QNAME;
        end
        PH_QPTR: begin
          phase_next = PH_QFIXED;
          label_next = '0;
        end
        PH_QFIXED: begin
          label_next = label + 8'd1;
          if (label_next >= QFIXED_LEN) begin
            phase_next = PH_ANAME;
            label_next = '0;
          end
        end
        PH_ANAME: begin
          if (item_byte == 8'd0) begin
            phase_next = PH_AFIXED;
            label_next = '0;
            fs_next    = '0;
          end else if ((item_byte & PTR_MARK) == PTR_MARK) begin
            phase_next = PH_APTR;
          end else begin
            label_next = item_byte;
            phase_next = PH_ALABEL;
          end
        end
        PH_ALABEL: begin
          label_next = label - 8'd1;
          if (label == 8'd1) phase_next = PH_ANAME;
        end
        PH_APTR: begin
          phase_next = PH_AFIXED;
          label_next = '0;
          fs_next    = '0;
        end
        PH_AFIXED: begin
          if (label < AHDR_LEN) hdr_next = {hdr[55:0], item_byte};
          else                  fs_next  = {fs[7:0], item_byte};
          label_next = label + 8'd1;
          if (label_next >= AFIXED_LEN) begin
            rdata_next = fs_next;
            if (fs_next == 16'd0) emit = 1'b1;
            else                  phase_next = PH_RDATA;
          end
        end
        PH_RDATA: begin
          addr_next  = {addr[119:0], item_byte};
          rdata_next = rdata - 16'd1;
          if (rdata == 16'd1) emit = 1'b1;
        end
        default: begin
        end
      endcase

      // Close the answer: count it, then stop or start the next one
      if (emit) begin
        number_next = number + CNT_W'(1);
        if (number_next >= wanted) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_ANAME;
          label_next = '0;
        end
      end
    end

    pos_next = (pos == POS_MAX) ? pos : pos + 16'd1;
  end

  // Answer check uses the header of the record and its data length
  assign base_ok = (hdr[47:32] == CLASS_IN) && (hdr[31:0] <= max_ttl);
  assign is_a    = base_ok && (hdr[63:48] == TYPE_A) && (fs_next == LEN_A);
  assign is_aaaa = base_ok && (hdr[63:48] == TYPE_AAAA) && (fs_next == LEN_AAAA);

  assign sum_status = (err_next != ST_OK)     ? err_next :
                      (phase_next != PH_DONE) ? ST_MALFORMED : ST_OK;

  always_comb begin
    push.ans_valid          = item_valid && emit;
    push.sum_valid          = item_valid && item_last;

    push.ans                = '0;
    push.ans.item_kind      = KIND_ANSWER;
    push.ans.answer_index   = number[IDX_W-1:0];
    push.ans.answer_ok      = is_a || is_aaaa;
    push.ans.addr_is_v6     = is_aaaa;
    push.ans.addr_high      = is_aaaa ? addr_next[127:64] : 64'd0;
    push.ans.addr_low       = is_aaaa ? addr_next[63:0]
                            : is_a    ? {32'd0, addr_next[31:0]} : 64'd0;

    push.sum                = '0;
    push.sum.item_kind      = KIND_SUMMARY;
    push.sum.overall_status = sum_status;
    push.sum.answer_count   = COUNT_W'(wanted_next);
    push.sum.last_result    = 1'b1;
  end

  // Field shifters and the address accumulator are always filled before use
  always_ff @(posedge clk) begin
    if (item_valid) begin
      fs   <= fs_next;
      hdr  <= hdr_next;
      addr <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (item_valid && item_last)) begin
      phase  <= PH_HEADER;
      pos    <= '0;
      label  <= '0;
      rdata  <= '0;
      wanted <= '0;
      number <= '0;
      err    <= ST_OK;
    end else if (item_valid) begin
      phase  <= phase_next;
      pos    <= pos_next;
      label  <= label_next;
      rdata  <= rdata_next;
      wanted <= wanted_next;
      number <= number_next;
      err    <= err_next;
    end
  end

endmodule
